@@ src/v4vu_pkg.sv @@
`default_nettype none
package v4vu_pkg;

    localparam int DW      = 32;        // vector and scalar width, Q16.16
    localparam int FB      = 16;        // fraction bits of vectors
    localparam int MW      = 16;        // matrix entry width, Q4.12
    localparam int MF      = MW - 4;    // fraction bits of matrix entries
    localparam int NL      = 4;         // lanes, one per component
    localparam int SQ_STG  = 33;        // root bits of a 66-bit radicand
    localparam int DV_STG  = FB + 1;    // quotient bits of normalize
    localparam int RAD_W   = 66;
    localparam int ROOT_W  = 33;

    typedef enum logic [3:0] {
        M_COPY   = 4'd0,
        M_ADDK   = 4'd1,
        M_SUBK   = 4'd2,
        M_SCALE  = 4'd3,
        M_NEG    = 4'd4,
        M_ADDV   = 4'd5,
        M_SUBV   = 4'd6,
        M_MATMUL = 4'd7,
        M_DOT    = 4'd8,
        M_NORM2  = 4'd9,
        M_NORM   = 4'd10,
        M_NORMZ  = 4'd11
    } t_mode;

    typedef enum logic [2:0] {
        CFG_EPS  = 3'd0,
        CFG_ROW0 = 3'd1,
        CFG_ROW1 = 3'd2,
        CFG_ROW2 = 3'd3,
        CFG_ROW3 = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [DW-1:0]          simple;   // saturated add/sub/negate result
        logic                   sflag;
        logic [2*DW-1:0]        prod;     // a times k, b or a
        logic [NL-1:0][DW+MW-1:0] mp;     // a times matrix row entries
    } t_lane;

    typedef struct packed {
        t_mode                  mode;
        logic [NL-1:0][DW-1:0]  a;
        logic [NL-1:0][DW-1:0]  r;
        logic [DW-1:0]          sc;
        logic                   sat;
        logic                   deg;
    } t_pay;

    typedef struct packed {
        logic [DW-1:0] val;
        logic          flag;
    } t_sat;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    function automatic t_sat sat66(input logic signed [65:0] v);
        t_sat s;
        if (v > SAT_HI) begin
            s.val  = SAT_HI[DW-1:0];
            s.flag = 1'b1;
        end else if (v < SAT_LO) begin
            s.val  = SAT_LO[DW-1:0];
            s.flag = 1'b1;
        end else begin
            s.val  = v[DW-1:0];
            s.flag = 1'b0;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

@@ src/v4vu_in_if.sv @@
`default_nettype none
interface v4vu_in_if import v4vu_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [3:0]            mode;
    logic signed [DW-1:0]  a0;
    logic signed [DW-1:0]  a1;
    logic signed [DW-1:0]  a2;
    logic signed [DW-1:0]  a3;
    logic signed [DW-1:0]  b0;
    logic signed [DW-1:0]  b1;
    logic signed [DW-1:0]  b2;
    logic signed [DW-1:0]  b3;
    logic signed [DW-1:0]  k_scalar;

    modport source (output valid, mode, a0, a1, a2, a3, b0, b1, b2, b3, k_scalar,
                    input ready);
    modport sink   (input valid, mode, a0, a1, a2, a3, b0, b1, b2, b3, k_scalar,
                    output ready);
endinterface
`default_nettype wire

@@ src/v4vu_out_if.sv @@
`default_nettype none
interface v4vu_out_if import v4vu_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic signed [DW-1:0]  r0;
    logic signed [DW-1:0]  r1;
    logic signed [DW-1:0]  r2;
    logic signed [DW-1:0]  r3;
    logic signed [DW-1:0]  scalar_out;
    logic                  degenerate;
    logic                  saturated;

    modport source (output valid, r0, r1, r2, r3, scalar_out, degenerate, saturated,
                    input ready);
    modport sink   (input valid, r0, r1, r2, r3, scalar_out, degenerate, saturated,
                    output ready);
endinterface
`default_nettype wire

@@ src/v4vu_lane.sv @@
`default_nettype none
module v4vu_lane import v4vu_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire t_mode                i_mode,
    input  wire logic signed [DW-1:0] i_a,
    input  wire logic signed [DW-1:0] i_b,
    input  wire logic signed [DW-1:0] i_k,
    input  wire logic [NL*MW-1:0]     i_mrow,
    output t_lane                     o_lane
);

    logic signed [DW:0]     n_sum;
    logic signed [DW-1:0]   n_opnd;
    logic signed [MW-1:0]   n_ent;
    logic signed [DW+MW-1:0] n_mp [NL];
    logic signed [2*DW-1:0] n_prod;
    t_sat                   n_sat;
    t_lane                  r_lane;

    always_comb begin
        case (i_mode)
            M_ADDK:  n_sum = i_a + i_k;
            M_SUBK:  n_sum = i_a - i_k;
            M_NEG:   n_sum = -{i_a[DW-1], i_a};
            M_ADDV:  n_sum = i_a + i_b;
            M_SUBV:  n_sum = i_a - i_b;
            default: n_sum = {i_a[DW-1], i_a};
        endcase
        n_sat = sat66({{(66-DW-1){n_sum[DW]}}, n_sum});

        case (i_mode)
            M_SCALE: n_opnd = i_k;
            M_DOT:   n_opnd = i_b;
            default: n_opnd = i_a;
        endcase
        n_prod = i_a * n_opnd;

        n_ent = '0;
        for (int j = 0; j < NL; j++) begin
            n_ent   = $signed(i_mrow[j*MW +: MW]);
            n_mp[j] = i_a * n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane.simple <= n_sat.val;
            r_lane.sflag  <= n_sat.flag;
            r_lane.prod   <= n_prod;
            for (int j = 0; j < NL; j++)
                r_lane.mp[j] <= n_mp[j];
        end
    end

    assign o_lane = r_lane;

endmodule
`default_nettype wire

@@ src/v4vu_merge.sv @@
`default_nettype none
module v4vu_merge import v4vu_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire t_mode                 i_mode,
    input  wire logic [NL-1:0][DW-1:0] i_a,
    input  wire t_lane [NL-1:0]        i_lane,
    output t_pay                       o_pay,
    output logic [RAD_W-1:0]           o_rad
);

    t_pay                    n_pay;
    t_pay                    r_pay;
    logic signed [RAD_W-1:0] n_psum;
    logic signed [49:0]      n_msum;
    logic signed [RAD_W-1:0] n_wide;
    t_sat                    n_sat;
    logic [RAD_W-1:0]        r_rad;

    always_comb begin
        n_pay      = '0;
        n_pay.mode = i_mode;
        n_pay.a    = i_a;
        n_psum     = '0;
        n_msum     = '0;
        n_wide     = '0;
        n_sat      = '0;
        for (int i = 0; i < NL; i++)
            n_psum = n_psum + RAD_W'($signed(i_lane[i].prod));

        case (i_mode)
            M_COPY: n_pay.r = i_a;
            M_ADDK, M_SUBK, M_NEG, M_ADDV, M_SUBV: begin
                for (int i = 0; i < NL; i++) begin
                    n_pay.r[i] = i_lane[i].simple;
                    n_pay.sat  = n_pay.sat | i_lane[i].sflag;
                end
            end
            M_SCALE: begin
                for (int i = 0; i < NL; i++) begin
                    n_wide = RAD_W'($signed(i_lane[i].prod) >>> FB);
                    n_sat  = sat66(n_wide);
                    n_pay.r[i] = n_sat.val;
                    n_pay.sat  = n_pay.sat | n_sat.flag;
                end
            end
            M_MATMUL: begin
                for (int j = 0; j < NL; j++) begin
                    n_msum = '0;
                    for (int i = 0; i < NL; i++)
                        n_msum = n_msum + 50'($signed(i_lane[i].mp[j]));
                    n_wide = RAD_W'(n_msum >>> MF);
                    n_sat  = sat66(n_wide);
                    n_pay.r[j] = n_sat.val;
                    n_pay.sat  = n_pay.sat | n_sat.flag;
                end
            end
            M_DOT, M_NORM2: begin
                n_wide    = n_psum >>> FB;
                n_sat     = sat66(n_wide);
                n_pay.sc  = n_sat.val;
                n_pay.sat = n_sat.flag;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay <= n_pay;
            r_rad <= n_psum;
        end
    end

    assign o_pay = r_pay;
    assign o_rad = r_rad;

endmodule
`default_nettype wire

@@ src/v4vu_sqrt.sv @@
`default_nettype none
module v4vu_sqrt import v4vu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0]      o_root
);

    // one root bit per stage, two radicand bits consumed per stage
    logic [RAD_W-1:0]  r_rad  [SQ_STG];
    logic [35:0]       r_rem  [SQ_STG];
    logic [ROOT_W-1:0] r_root [SQ_STG];

    for (genvar s = 0; s < SQ_STG; s++) begin : g_stg
        logic [RAD_W-1:0]  n_rad;
        logic [35:0]       n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [35:0]       n_cur;
        logic [35:0]       n_trial;

        if (s == 0) begin : g_first
            assign n_rad  = i_rad;
            assign n_rem  = '0;
            assign n_root = '0;
        end else begin : g_next
            assign n_rad  = r_rad[s-1];
            assign n_rem  = r_rem[s-1];
            assign n_root = r_root[s-1];
        end

        assign n_cur   = {n_rem[33:0], n_rad[RAD_W-1 -: 2]};
        assign n_trial = {1'b0, n_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s] <= {n_rad[RAD_W-3:0], 2'b00};
                if (n_cur >= n_trial) begin
                    r_rem[s]  <= n_cur - n_trial;
                    r_root[s] <= {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= n_cur;
                    r_root[s] <= {n_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SQ_STG-1];

endmodule
`default_nettype wire

@@ src/v4vu_div.sv @@
`default_nettype none
module v4vu_div import v4vu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DW-1:0]     i_num,
    input  wire logic [ROOT_W-1:0] i_den,
    output logic [DV_STG-1:0]      o_quo
);

    // restoring division, quotient bit DV_STG-1-s decided in stage s;
    // the norm bounds every component, so the quotient fits DV_STG bits
    localparam int NW = DW + FB;
    localparam int SW = NW + 2;

    logic [NW-1:0]     r_rem [DV_STG];
    logic [DV_STG-1:0] r_quo [DV_STG];
    logic [ROOT_W-1:0] r_den [DV_STG];

    for (genvar s = 0; s < DV_STG; s++) begin : g_stg
        logic [NW-1:0]     n_rem;
        logic [DV_STG-1:0] n_quo;
        logic [ROOT_W-1:0] n_den;
        logic [SW-1:0]     n_sub;

        if (s == 0) begin : g_first
            assign n_rem = {i_num, {FB{1'b0}}};
            assign n_quo = '0;
            assign n_den = i_den;
        end else begin : g_next
            assign n_rem = r_rem[s-1];
            assign n_quo = r_quo[s-1];
            assign n_den = r_den[s-1];
        end

        assign n_sub = SW'(n_den) << (DV_STG - 1 - s);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= n_den;
                if ({2'b00, n_rem} >= n_sub) begin
                    r_rem[s] <= n_rem - n_sub[NW-1:0];
                    r_quo[s] <= n_quo | (DV_STG'(1) << (DV_STG - 1 - s));
                end else begin
                    r_rem[s] <= n_rem;
                    r_quo[s] <= n_quo;
                end
            end
        end
    end

    assign o_quo = r_quo[DV_STG-1];

endmodule
`default_nettype wire

@@ src/vec4_vector_unit.sv @@
`default_nettype none
// Four-component fixed-point vector unit (Q16.16 vectors, Q4.12 matrix).
//
// Channels: i_vec carries one item per transfer (mode, a0..a3, b0..b3,
// k_scalar); o_res carries one result per item (r0..r3, scalar_out,
// degenerate, saturated), in input order. Configuration goes through the
// write port: i_cfg_we with i_cfg_idx 0 writes eps_threshold, 1..4 write
// matrix rows 0..3. Write it only while no item is in flight.
//
// Throughput: one item per cycle unless o_res stalls. The pipeline length
// is set by the square root pipeline (33 stages, one root bit each)
// followed by the normalize divider (17 stages, one quotient bit each),
// ahead of which sit the lane products and the merging adders, one stage
// each, with the output register at the end.
//
// Every mode takes the same path, so results never reorder.
// Stall: the whole pipeline holds while o_res is valid and not ready;
// i_vec.ready drops in the same cycle, and nothing is lost.
// Reset: clears every valid bit, loads eps_threshold = 1 and the identity
// matrix. No clearing pass; the block takes items right after reset.
module vec4_vector_unit import v4vu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    v4vu_in_if.sink         i_vec,
    v4vu_out_if.source      o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    localparam int NSTG = 2 + SQ_STG + DV_STG;

    // configuration
    logic [30:0]          r_eps;
    logic [NL*MW-1:0]     r_mrow [NL];

    // pipeline control
    logic                 w_en;
    logic [NSTG-1:0]      r_vld;
    logic                 r_out_vld;

    // lanes and merge
    t_mode                w_mode;
    logic signed [DW-1:0] w_a [NL];
    logic signed [DW-1:0] w_b [NL];
    t_lane [NL-1:0]       w_lane;
    t_mode                r_mode1;
    logic [NL-1:0][DW-1:0] r_a1;
    t_pay                 w_mpay;
    logic [RAD_W-1:0]     w_rad;

    // root and divider
    logic [ROOT_W-1:0]    w_root;
    t_pay                 r_psq [SQ_STG];
    t_pay                 n_pdv;
    t_pay                 r_pdv [DV_STG];
    logic [DW-1:0]        w_num [NL];
    logic [DV_STG-1:0]    w_quo [NL];

    // output register
    t_pay                 n_out;
    t_pay                 r_out;

    // advance every stage together unless the result register is blocked
    assign w_en        = !r_out_vld || o_res.ready;
    assign i_vec.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps     <= 31'd1;
            for (int i = 0; i < NL; i++)
                r_mrow[i] <= (NL*MW)'(1 << MF) << (MW * i);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_EPS:  r_eps     <= i_cfg_data[30:0];
                CFG_ROW0: r_mrow[0] <= i_cfg_data;
                CFG_ROW1: r_mrow[1] <= i_cfg_data;
                CFG_ROW2: r_mrow[2] <= i_cfg_data;
                CFG_ROW3: r_mrow[3] <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[NSTG-2:0], i_vec.valid};
            r_out_vld <= r_vld[NSTG-1];
        end
    end

    assign w_mode = t_mode'(i_vec.mode);
    assign w_a[0] = i_vec.a0;
    assign w_a[1] = i_vec.a1;
    assign w_a[2] = i_vec.a2;
    assign w_a[3] = i_vec.a3;
    assign w_b[0] = i_vec.b0;
    assign w_b[1] = i_vec.b1;
    assign w_b[2] = i_vec.b2;
    assign w_b[3] = i_vec.b3;

    // stage 1: one lane per component, lane i owns matrix row i
    for (genvar i = 0; i < NL; i++) begin : g_lane
        v4vu_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mode (w_mode),
            .i_a    (w_a[i]),
            .i_b    (w_b[i]),
            .i_k    (i_vec.k_scalar),
            .i_mrow (r_mrow[i]),
            .o_lane (w_lane[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mode1 <= w_mode;
            for (int i = 0; i < NL; i++)
                r_a1[i] <= w_a[i];
        end
    end

    // stage 2: combine lane products into the final values of most modes
    v4vu_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mode (r_mode1),
        .i_a    (r_a1),
        .i_lane (w_lane),
        .o_pay  (w_mpay),
        .o_rad  (w_rad)
    );

    // square root of the sum of squares; payload rides alongside
    v4vu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (w_rad),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_psq[0] <= w_mpay;
            for (int s = 1; s < SQ_STG; s++)
                r_psq[s] <= r_psq[s-1];
        end
    end

    // norm result and the fallback decision for normalize
    always_comb begin
        n_pdv = r_psq[SQ_STG-1];
        case (n_pdv.mode)
            M_NORM: begin
                if (w_root > ROOT_W'(SAT_HI[DW-1:0])) begin
                    n_pdv.sc  = SAT_HI[DW-1:0];
                    n_pdv.sat = 1'b1;
                end else begin
                    n_pdv.sc  = w_root[DW-1:0];
                end
            end
            M_NORMZ: n_pdv.deg = (w_root <= {2'b00, r_eps});
            default: ;
        endcase
        for (int i = 0; i < NL; i++)
            w_num[i] = n_pdv.a[i][DW-1] ? DW'(-n_pdv.a[i]) : n_pdv.a[i];
    end

    for (genvar i = 0; i < NL; i++) begin : g_div
        v4vu_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[i]),
            .i_den (w_root),
            .o_quo (w_quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pdv[0] <= n_pdv;
            for (int s = 1; s < DV_STG; s++)
                r_pdv[s] <= r_pdv[s-1];
        end
    end

    // apply signs to the normalize quotients, or drop in the fallback vector
    always_comb begin
        n_out = r_pdv[DV_STG-1];
        if (n_out.mode == M_NORMZ) begin
            n_out.sat = 1'b0;
            n_out.sc  = '0;
            for (int i = 0; i < NL; i++) begin
                if (n_out.deg)
                    n_out.r[i] = (i == 0) ? DW'(1 << FB) : '0;
                else if (n_out.a[i][DW-1])
                    n_out.r[i] = -DW'(w_quo[i]);
                else
                    n_out.r[i] = DW'(w_quo[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en)
            r_out <= n_out;
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.r0         = r_out.r[0];
    assign o_res.r1         = r_out.r[1];
    assign o_res.r2         = r_out.r[2];
    assign o_res.r3         = r_out.r[3];
    assign o_res.scalar_out = r_out.sc;
    assign o_res.degenerate = r_out.deg;
    assign o_res.saturated  = r_out.sat;

endmodule
`default_nettype wire

@@ src/v4vu_chk.sv @@
`default_nettype none
module v4vu_chk import v4vu_pkg::*; (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_valid,
    input wire logic          i_ready,
    input wire logic [DW-1:0] i_r0,
    input wire logic [DW-1:0] i_r1,
    input wire logic [DW-1:0] i_r2,
    input wire logic [DW-1:0] i_r3,
    input wire logic [DW-1:0] i_sc,
    input wire logic          i_deg,
    input wire logic          i_sat
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_r0) && $stable(i_sc))
        else $error("stalled result changed");

    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_deg |-> i_r0 == DW'(1 << FB) && i_r1 == '0 && i_r2 == '0
                             && i_r3 == '0 && !i_sat && i_sc == '0)
        else $error("fallback vector malformed");

    a_scalar_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_sc != '0 |-> i_r0 == '0 && i_r1 == '0 && i_r2 == '0
                                  && i_r3 == '0 && !i_deg)
        else $error("scalar result mixed with vector result");

endmodule

bind vec4_vector_unit v4vu_chk u_v4vu_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_r0    (o_res.r0),
    .i_r1    (o_res.r1),
    .i_r2    (o_res.r2),
    .i_r3    (o_res.r3),
    .i_sc    (o_res.scalar_out),
    .i_deg   (o_res.degenerate),
    .i_sat   (o_res.saturated)
);
`default_nettype wire
